FILE: hdl/rhb_pkg.sv
// ----------------------------------------------------------------------------
// rhb_pkg: shared types and constants for the RGB to HSV byte converter
// Widths of the pixel fields and of the divider datapath that runs through
// the row of division cells.
// ----------------------------------------------------------------------------
package rhb_pkg;

	// Pixel channel width.
	localparam int unsigned ChanW = 8;

	// Number of division cells, one per quotient bit.
	localparam int unsigned NumCells = ChanW;

	// Saturation divider: divisor is M (8 bits), remainder stays below M << 8.
	localparam int unsigned SatDivW = ChanW;
	localparam int unsigned SatRemW = SatDivW + NumCells;

	// Hue divider: divisor is 6C (11 bits), remainder stays below 6C << 8.
	localparam int unsigned HueDivW = 11;
	localparam int unsigned HueRemW = HueDivW + NumCells;

	// Data handed from one cell to the next.
	typedef struct packed {
		logic [SatRemW-1:0] sat_rem;
		logic [SatDivW-1:0] sat_div;
		logic [HueRemW-1:0] hue_rem;
		logic [HueDivW-1:0] hue_div;
		logic [ChanW-1:0]   sat_quo;
		logic [ChanW-1:0]   hue_quo;
		logic [ChanW-1:0]   value;
	} rhb_stage_t;

endpackage

FILE: hdl/rhb_rgb_if.sv
// ----------------------------------------------------------------------------
// rhb_rgb_if: RGB pixel channel
// Valid/ready channel carrying one 8-bit RGB pixel per beat.
// ----------------------------------------------------------------------------
interface rhb_rgb_if
	import rhb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] blue;
	logic [ChanW-1:0] green;
	logic [ChanW-1:0] red;

	modport source (output valid, output blue, output green, output red, input ready);
	modport sink (input valid, input blue, input green, input red, output ready);
endinterface

FILE: hdl/rhb_hsv_if.sv
// ----------------------------------------------------------------------------
// rhb_hsv_if: HSV pixel channel
// Valid/ready channel carrying one 8-bit HSV pixel per beat.
// ----------------------------------------------------------------------------
interface rhb_hsv_if
	import rhb_pkg::*;
();
	logic             valid;
	logic             ready;
	logic [ChanW-1:0] hue;
	logic [ChanW-1:0] saturation;
	logic [ChanW-1:0] value;

	modport source (output valid, output hue, output saturation, output value, input ready);
	modport sink (input valid, input hue, input saturation, input value, output ready);
endinterface

FILE: hdl/rhb_front.sv
// ----------------------------------------------------------------------------
// rhb_front: min/max and dividend preparation stage
// Finds max, min and chroma of the pixel, picks the hue sector and forms the
// scaled dividends and divisors for the division cells.
// ----------------------------------------------------------------------------
module rhb_front
	import rhb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	rhb_rgb_if.sink     rgb,
	output logic        dn_valid,
	output rhb_stage_t  dn_data,
	input  logic        dn_ready
);

	logic [ChanW-1:0]   mx;
	logic [ChanW-1:0]   mn;
	logic [ChanW-1:0]   chroma;
	logic [HueDivW-1:0] c_w;
	logic [HueDivW-1:0] den;
	logic [HueDivW-1:0] num;
	logic               gray;
	rhb_stage_t         nxt;
	logic               valid_q;
	rhb_stage_t         data_q;

	// Largest and smallest channel and the chroma between them.
	always_comb begin
		mx = (rgb.red > rgb.green) ? rgb.red : rgb.green;
		mx = (mx > rgb.blue) ? mx : rgb.blue;
		mn = (rgb.red < rgb.green) ? rgb.red : rgb.green;
		mn = (mn < rgb.blue) ? mn : rgb.blue;
		chroma = mx - mn;
		gray = (chroma == '0);
		c_w = {{(HueDivW-ChanW){1'b0}}, chroma};
		den = (c_w << 2) + (c_w << 1);
	end

	// Hue numerator with blue taking priority over green, green over red.
	always_comb begin
		priority if (mx == rgb.blue) begin
			num = (c_w << 2) + {{(HueDivW-ChanW){1'b0}}, rgb.red}
				- {{(HueDivW-ChanW){1'b0}}, rgb.green};
		end else if (mx == rgb.green) begin
			num = (c_w << 1) + {{(HueDivW-ChanW){1'b0}}, rgb.blue}
				- {{(HueDivW-ChanW){1'b0}}, rgb.red};
		end else if (rgb.green >= rgb.blue) begin
			num = {{(HueDivW-ChanW){1'b0}}, rgb.green - rgb.blue};
		end else begin
			num = {{(HueDivW-ChanW){1'b0}}, rgb.green} + den
				- {{(HueDivW-ChanW){1'b0}}, rgb.blue};
		end
	end

	// Dividends are 255 times the numerators; a gray pixel divides zero by one.
	always_comb begin
		nxt.value   = mx;
		nxt.sat_quo = '0;
		nxt.hue_quo = '0;
		if (gray) begin
			nxt.sat_rem = '0;
			nxt.sat_div = SatDivW'(1);
			nxt.hue_rem = '0;
			nxt.hue_div = HueDivW'(1);
		end else begin
			nxt.sat_rem = ({{(SatRemW-ChanW){1'b0}}, chroma} << 8)
				- {{(SatRemW-ChanW){1'b0}}, chroma};
			nxt.sat_div = mx;
			nxt.hue_rem = ({{(HueRemW-HueDivW){1'b0}}, num} << 8)
				- {{(HueRemW-HueDivW){1'b0}}, num};
			nxt.hue_div = den;
		end
	end

	assign rgb.ready = !valid_q || dn_ready;

	// Stage valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (rgb.ready) begin
			valid_q <= rgb.valid;
		end
	end

	// Stage payload.
	always_ff @(posedge clk) begin
		if (rgb.ready && rgb.valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

FILE: hdl/rhb_div_cell.sv
// ----------------------------------------------------------------------------
// rhb_div_cell: one restoring division step for saturation and hue
// Each cell settles one quotient bit of both divisions and hands the shifted
// remainders on to its neighbor.
// ----------------------------------------------------------------------------
module rhb_div_cell
	import rhb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        up_valid,
	input  rhb_stage_t  up_data,
	output logic        up_ready,
	output logic        dn_valid,
	output rhb_stage_t  dn_data,
	input  logic        dn_ready
);

	logic [SatRemW-1:0] sat_trial;
	logic [HueRemW-1:0] hue_trial;
	logic [SatRemW-1:0] sat_left;
	logic [HueRemW-1:0] hue_left;
	logic               sat_bit;
	logic               hue_bit;
	rhb_stage_t         nxt;
	logic               valid_q;
	rhb_stage_t         data_q;

	// Compare against the divisor at the top quotient position, subtract,
	// then shift the remainder up for the next cell.
	always_comb begin
		sat_trial = {{(SatRemW-SatDivW){1'b0}}, up_data.sat_div} << (NumCells - 1);
		hue_trial = {{(HueRemW-HueDivW){1'b0}}, up_data.hue_div} << (NumCells - 1);
		sat_bit   = (up_data.sat_rem >= sat_trial);
		hue_bit   = (up_data.hue_rem >= hue_trial);
		sat_left  = sat_bit ? (up_data.sat_rem - sat_trial) : up_data.sat_rem;
		hue_left  = hue_bit ? (up_data.hue_rem - hue_trial) : up_data.hue_rem;
		nxt         = up_data;
		nxt.sat_rem = sat_left << 1;
		nxt.hue_rem = hue_left << 1;
		nxt.sat_quo = {up_data.sat_quo[ChanW-2:0], sat_bit};
		nxt.hue_quo = {up_data.hue_quo[ChanW-2:0], hue_bit};
	end

	assign up_ready = !valid_q || dn_ready;

	// Cell valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	// Cell payload.
	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			data_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_data  = data_q;

endmodule

FILE: hdl/rgb_to_hsv_byte_unit.sv
// An accepted input beat passes through the front stage register and then each
// division cell register in turn. Throughput: one pixel per cycle while the output is ready; each stage
// holds one pixel and moves on whenever the stage after it is empty or advancing.
// The front stage plus a row of 8 division cells, one quotient bit per cell.
// Reset empties every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
// rgb_to_hsv_byte_unit: 8-bit RGB to 8-bit HSV converter
// Front stage prepares dividends, a chain of division cells produces the
// saturation and hue quotients, and the last cell drives the output channel.
// ----------------------------------------------------------------------------
module rgb_to_hsv_byte_unit
	import rhb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	rhb_rgb_if.sink rgb,
	rhb_hsv_if.source hsv
);

	logic       link_valid [NumCells+1];
	rhb_stage_t link_data  [NumCells+1];
	logic       link_ready [NumCells+1];

	// Min/max and dividend stage.
	rhb_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.rgb      (rgb),
		.dn_valid (link_valid[0]),
		.dn_data  (link_data[0]),
		.dn_ready (link_ready[0])
	);

	// Row of division cells.
	for (genvar k = 0; k < NumCells; k++) begin : g_cell
		rhb_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (link_valid[k]),
			.up_data  (link_data[k]),
			.up_ready (link_ready[k]),
			.dn_valid (link_valid[k+1]),
			.dn_data  (link_data[k+1]),
			.dn_ready (link_ready[k+1])
		);
	end

	// The last cell register is the output register.
	assign hsv.valid            = link_valid[NumCells];
	assign hsv.hue              = link_data[NumCells].hue_quo;
	assign hsv.saturation       = link_data[NumCells].sat_quo;
	assign hsv.value            = link_data[NumCells].value;
	assign link_ready[NumCells] = hsv.ready;

endmodule
